@@ rtl/ghb_pkg.sv @@
// Package for the gradient histogram builder.
// Holds field widths, payload structs, opcodes, register indexes and the
// controller/datapath command and status structs. No dependencies.
package ghb_pkg;

  localparam int OP_W       = 2;
  localparam int FEAT_W     = 8;
  localparam int BIN_W      = 11;
  localparam int OFFS_W     = 10;
  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = 48;
  localparam int BIN_READ_W = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int LIM_W      = 17;

  localparam int NUM_BINS_DEF     = 1024;
  localparam int MAX_FEATURES_DEF = 256;

  localparam logic [CFG_DATA_W-1:0] BINS_IN_USE_RST = CFG_DATA_W'(1024);

  localparam logic [CFG_IDX_W-1:0] CFG_DENSE_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 1'd1;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_OFFSET = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]            op;
    logic [FEAT_W-1:0]          feature;
    logic [BIN_W-1:0]           bin;
    logic [OFFS_W-1:0]          offset_value;
    logic signed [SAMPLE_W-1:0] grad;
    logic signed [SAMPLE_W-1:0] hess;
  } ghb_in_t;

  typedef struct packed {
    logic [BIN_READ_W-1:0]   bin_read;
    logic signed [SUM_W-1:0] grad_sum;
    logic signed [SUM_W-1:0] hess_sum;
  } ghb_out_t;

  typedef struct packed {
    logic item_cap;
    logic off_wr;
    logic sum_rd;
    logic sum_wr_acc;
    logic sum_wr_zero;
    logic clr_wr;
    logic out_load;
  } ghb_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            add_ok;
    logic            read_ok;
    logic            feature_ok;
    logic            clr_last;
    logic            out_busy;
  } ghb_status_t;

endpackage

@@ rtl/ghb_stream_if.sv @@
// Valid/ready stream interface used for the item and result channels.
// Payload type is a parameter; payload structs come from ghb_pkg.
interface ghb_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/gradient_histogram_builder.sv @@
// Gradient histogram builder top level: ghb_ctrl plus ghb_dp.
// Depends on ghb_pkg, ghb_stream_if, ghb_ctrl and ghb_dp.
//
// Usage: items arrive on in_i (valid/ready), results leave on out_o.
// op add sums grad/hess into a bin (dense: local bin + feature offset,
// sparse: global bin; any target >= bins_in_use is skipped); op offset
// writes a feature offset; op read returns a bin's sums and clears it.
// Configuration (dense_mode index 0, bins_in_use index 1) is written through
// cfg_we_i / cfg_index_i / cfg_data_i while the block is idle.
// Items are handled one at a time: add passes through decode and accumulate,
// read through decode and the read state, offset writes and dropped items
// through decode alone, before in_i.ready rises again. The states follow the
// registered offset read and then the registered read-modify-write of the sum
// memories. A read result sits in an output register, so the next item is
// taken while the receiver stalls; a second read waits for that register.
// After reset a clearing pass writes zero to every bin with in_i.ready low;
// configuration writes are taken meanwhile.
module gradient_histogram_builder #(
  parameter int NUM_BINS     = ghb_pkg::NUM_BINS_DEF,
  parameter int MAX_FEATURES = ghb_pkg::MAX_FEATURES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ghb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ghb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ghb_stream_if.sink                     in_i,
  ghb_stream_if.source                   out_o
);

  ghb_pkg::ghb_cmd_t    cmd;
  ghb_pkg::ghb_status_t status;

  ghb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ghb_dp #(
    .NUM_BINS     (NUM_BINS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.payload),
    .out_data_o  (out_o.payload),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("item taken while previous item in progress");

  a_no_input_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !in_i.ready)
    else $error("input ready during clearing pass");

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_o.valid && !out_o.ready))
    else $error("result loaded over a stalled result");

  a_no_rd_wr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sum_rd |-> !(cmd.sum_wr_acc || cmd.sum_wr_zero || cmd.clr_wr))
    else $error("sum memory read and write in the same cycle");

endmodule

@@ rtl/ghb_ctrl.sv @@
// Controller for the gradient histogram builder: clear sweep, item decode
// and memory sequencing. Uses ghb_pkg command and status structs.
module ghb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ghb_pkg::ghb_status_t status_i,
  output ghb_pkg::ghb_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ACC,
    ST_READ
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_cap = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        case (status_i.op)
          ghb_pkg::OP_ADD: begin
            if (status_i.add_ok) begin
              cmd_o.sum_rd = 1'b1;
              state_d      = ST_ACC;
            end
          end
          ghb_pkg::OP_OFFSET: begin
            cmd_o.off_wr = status_i.feature_ok;
          end
          ghb_pkg::OP_READ: begin
            if (status_i.read_ok) begin
              cmd_o.sum_rd = 1'b1;
              state_d      = ST_READ;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_ACC: begin
        cmd_o.sum_wr_acc = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_READ: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load    = 1'b1;
          cmd_o.sum_wr_zero = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/ghb_dp.sv @@
// Datapath for the gradient histogram builder: config registers, offset
// memory, sum memories with saturating accumulate, output register.
// Uses ghb_pkg types; driven by ghb_ctrl commands.
module ghb_dp #(
  parameter int NUM_BINS     = ghb_pkg::NUM_BINS_DEF,
  parameter int MAX_FEATURES = ghb_pkg::MAX_FEATURES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ghb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ghb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  ghb_pkg::ghb_in_t                 in_data_i,
  output ghb_pkg::ghb_out_t                out_data_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  input  ghb_pkg::ghb_cmd_t                cmd_i,
  output ghb_pkg::ghb_status_t             status_o
);

  localparam int BIN_AW  = $clog2(NUM_BINS);
  localparam int FEAT_AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int LIM_W   = ghb_pkg::LIM_W;
  localparam int SUM_W   = ghb_pkg::SUM_W;
  localparam int SMP_W   = ghb_pkg::SAMPLE_W;

  localparam logic [LIM_W-1:0]  NUM_BINS_L = LIM_W'(NUM_BINS);
  localparam logic [LIM_W-1:0]  MAX_FEAT_L = LIM_W'(MAX_FEATURES);
  localparam logic [BIN_AW-1:0] LAST_BIN   = BIN_AW'(NUM_BINS - 1);

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] acc,
    input logic [SMP_W-1:0]        raw
  );
    logic [SUM_W:0] sum;
    sum = {acc[SUM_W-1], acc} + {{(SUM_W + 1 - SMP_W){raw[SMP_W-1]}}, raw};
    if (sum[SUM_W] != sum[SUM_W-1]) begin
      sat_add = sum[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sat_add = sum[SUM_W-1:0];
    end
  endfunction

  logic                             dense_q;
  logic [ghb_pkg::CFG_DATA_W-1:0]   bins_q;
  ghb_pkg::ghb_in_t                 item_q;
  logic [ghb_pkg::OFFS_W-1:0]       off_mem [MAX_FEATURES];
  logic [ghb_pkg::OFFS_W-1:0]       off_rd_q;
  logic signed [SUM_W-1:0]          grad_mem [NUM_BINS];
  logic signed [SUM_W-1:0]          hess_mem [NUM_BINS];
  logic signed [SUM_W-1:0]          grad_rd_q, hess_rd_q;
  logic [BIN_AW-1:0]                addr_q;
  logic [BIN_AW-1:0]                clr_cnt_q;
  ghb_pkg::ghb_out_t                out_q;
  logic                             out_valid_q;

  logic [LIM_W-1:0]        in_feat_l, feat_l, bin_l, bins_l, limit, target;
  logic                    feature_ok, add_ok, read_ok;
  logic [BIN_AW-1:0]       rd_addr, wr_addr;
  logic                    sum_we;
  logic signed [SUM_W-1:0] grad_new, hess_new, grad_wd, hess_wd;

  assign in_feat_l  = LIM_W'(in_data_i.feature);
  assign feat_l     = LIM_W'(item_q.feature);
  assign bin_l      = LIM_W'(item_q.bin);
  assign bins_l     = LIM_W'(bins_q);
  assign limit      = (bins_l > NUM_BINS_L) ? NUM_BINS_L : bins_l;
  assign target     = dense_q ? bin_l + LIM_W'(off_rd_q) : bin_l;
  assign feature_ok = feat_l < MAX_FEAT_L;
  assign add_ok     = (!dense_q || feature_ok) && (target < limit);
  assign read_ok    = bin_l < NUM_BINS_L;
  assign rd_addr    = (item_q.op == ghb_pkg::OP_READ) ? bin_l[BIN_AW-1:0]
                                                      : target[BIN_AW-1:0];

  assign grad_new = sat_add(grad_rd_q, item_q.grad[SMP_W-1:0]);
  assign hess_new = sat_add(hess_rd_q, item_q.hess[SMP_W-1:0]);
  assign sum_we   = cmd_i.clr_wr | cmd_i.sum_wr_acc | cmd_i.sum_wr_zero;
  assign wr_addr  = cmd_i.clr_wr ? clr_cnt_q : addr_q;
  assign grad_wd  = cmd_i.sum_wr_acc ? grad_new : '0;
  assign hess_wd  = cmd_i.sum_wr_acc ? hess_new : '0;

  always_comb begin
    status_o            = '0;
    status_o.op         = item_q.op;
    status_o.add_ok     = add_ok;
    status_o.read_ok    = read_ok;
    status_o.feature_ok = feature_ok;
    status_o.clr_last   = clr_cnt_q == LAST_BIN;
    status_o.out_busy   = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dense_q     <= 1'b0;
      bins_q      <= ghb_pkg::BINS_IN_USE_RST;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          ghb_pkg::CFG_DENSE_MODE:  dense_q <= cfg_data_i[0];
          ghb_pkg::CFG_BINS_IN_USE: bins_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + BIN_AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_cap) begin
      item_q   <= in_data_i;
      off_rd_q <= off_mem[in_feat_l[FEAT_AW-1:0]];
    end
    if (cmd_i.off_wr) begin
      off_mem[feat_l[FEAT_AW-1:0]] <= item_q.offset_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_rd) begin
      grad_rd_q <= grad_mem[rd_addr];
      hess_rd_q <= hess_mem[rd_addr];
      addr_q    <= rd_addr;
    end
    if (sum_we) begin
      grad_mem[wr_addr] <= grad_wd;
      hess_mem[wr_addr] <= hess_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.bin_read <= item_q.bin[ghb_pkg::BIN_READ_W-1:0];
      out_q.grad_sum <= grad_rd_q;
      out_q.hess_sum <= hess_rd_q;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule
